>>> rtl/core/cht_pkg.sv
// Package for the coalesced hash table: transaction payload types,
// operation codes and slot mark codes.
// No dependencies.
`default_nettype none
package cht_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_FILLED  = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] item_key;
        logic signed [KEY_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic       success;
        logic [4:0] filled_slots;
    } t_out;

endpackage
`default_nettype wire

>>> rtl/core/cht_home.sv
// Home slot unit: |key| mod TABLE_SLOTS by reciprocal multiplication and one
// correcting subtract, pipelined through r_mag, r_quo and r_rem. Depends on cht_pkg.
`default_nettype none
module cht_home #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [cht_pkg::KEY_W-1:0]      i_key,
    output logic                                o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0]      o_home
);
    import cht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW:0] N_W = (IW+1)'(TABLE_SLOTS);
    localparam logic [KEY_W-1:0] N_K = KEY_W'(TABLE_SLOTS);
    // floor(2^KEY_W / TABLE_SLOTS): the quotient estimate is low by at most one
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SLOTS);

    logic [KEY_W-1:0]   r_mag;
    logic [KEY_W-1:0]   r_mag_q;
    logic [KEY_W-1:0]   r_quo;
    logic [IW-1:0]      r_rem;
    logic               r_v_mul;
    logic               r_v_sub;
    logic               r_done;
    logic [KEY_W-1:0]   mag;
    logic [2*KEY_W-1:0] prod;
    logic [KEY_W-1:0]   quo_n;
    logic [KEY_W-1:0]   diff;
    logic [IW:0]        reduced;

    // Magnitude of the signed key, taken as an unsigned word
    assign mag = i_key[KEY_W-1] ? (~i_key + KEY_W'(1)) : i_key;

    // Estimate the quotient, then the remainder lies below twice the modulus
    assign prod    = (2*KEY_W)'(r_mag) * (2*KEY_W)'(RECIP);
    assign quo_n   = r_quo * N_K;
    assign diff    = r_mag_q - quo_n;
    assign reduced = (diff[IW:0] >= N_W) ? (diff[IW:0] - N_W) : diff[IW:0];

    // Advance the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_sub <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_v_mul <= i_start;
            r_v_sub <= r_v_mul;
            r_done  <= r_v_sub;
        end
    end

    // Capture the key, the quotient estimate and the final remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= mag;
        end
        if (r_v_mul) begin
            r_quo   <= prod[2*KEY_W-1:KEY_W];
            r_mag_q <= r_mag;
        end
        if (r_v_sub) begin
            r_rem <= reduced[IW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule
`default_nettype wire

>>> rtl/core/coalesced_hash_table.sv
// Coalesced hash table top level, one transaction at a time: hash to a home
// slot, walk its chain by registered reads, decide, output; an insert whose
// home is taken also scans for a free slot and walks the home chain to link it.
// Input reopens the cycle after the result loads; a stalled result holds the
// input. The mark/link memory read port sets the step rate. Reset runs a
// clearing pass over every slot with input stalled. Uses cht_pkg.
`default_nettype none
module coalesced_hash_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire cht_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output cht_pkg::t_out      o_out_data
);
    import cht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_SLOTS);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HASH = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FEV  = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SEV  = 4'd7;
    localparam logic [3:0] S_WRD  = 4'd8;
    localparam logic [3:0] S_WEV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    typedef struct packed {
        logic [1:0]    mark;
        logic          lv;
        logic [IW-1:0] link;
    } t_meta;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] data;
    } t_kv;

    t_meta mem_meta [TABLE_SLOTS];
    t_kv   mem_kv   [TABLE_SLOTS];
    t_meta rd_meta;
    t_kv   rd_kv;

    logic [3:0]       r_state, n_state;
    logic [IW-1:0]    r_cur, n_cur;
    logic [IW-1:0]    r_steps, n_steps;
    logic [IW-1:0]    r_home, n_home;
    logic [IW-1:0]    r_slot, n_slot;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_found, n_found;
    logic             r_ok, n_ok;
    t_meta            r_hmeta, n_hmeta;
    t_meta            r_fmeta, n_fmeta;
    logic [CW-1:0]    r_count, n_count;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_val;
    logic             r_out_valid;
    t_out             r_out;

    logic             meta_we;
    logic [IW-1:0]    meta_wa;
    t_meta            meta_wd;
    logic             kv_we;
    logic [IW-1:0]    kv_wa;
    logic             accept;
    logic             hash_done;
    logic [IW-1:0]    hash_home;
    logic [CW+4:0]    count_ext;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    cht_home #(.TABLE_SLOTS(TABLE_SLOTS)) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_in_data.item_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    // Slot memories: one write port, one registered read at the walk pointer
    always_ff @(posedge i_clk) begin
        if (meta_we) mem_meta[meta_wa] <= meta_wd;
        if (kv_we) mem_kv[kv_wa] <= '{key: r_key, data: r_val};
        rd_meta <= mem_meta[r_cur];
        rd_kv   <= mem_kv[r_cur];
    end

    // Sequencer: clearing pass, hash, chain search, insert/delete updates, output
    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_steps = r_steps;
        n_home  = r_home;
        n_slot  = r_slot;
        n_idx   = r_idx;
        n_found = r_found;
        n_ok    = r_ok;
        n_hmeta = r_hmeta;
        n_fmeta = r_fmeta;
        n_count = r_count;
        meta_we = 1'b0;
        meta_wa = r_cur;
        meta_wd = '0;
        kv_we   = 1'b0;
        kv_wa   = r_cur;
        unique case (r_state)
            S_CLR: begin
                meta_we = 1'b1;
                n_cur   = r_cur + IW'(1);
                if (r_cur == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_home  = hash_home;
                    n_cur   = hash_home;
                    n_steps = '0;
                    n_found = 1'b0;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                n_state = S_FEV;
            end
            S_FEV: begin
                if (r_steps == '0) begin
                    n_hmeta = rd_meta;
                end
                if (rd_meta.mark == MARK_FILLED && rd_kv.key == r_key) begin
                    n_found = 1'b1;
                    n_idx   = r_cur;
                    n_fmeta = rd_meta;
                    n_state = S_DEC;
                end else if (!rd_meta.lv || r_steps == LAST) begin
                    n_state = S_DEC;
                end else begin
                    n_cur   = rd_meta.link;
                    n_steps = r_steps + IW'(1);
                    n_state = S_FRD;
                end
            end
            S_DEC: begin
                n_ok    = 1'b0;
                n_state = S_OUT;
                priority if (r_op == OP_LOOKUP) begin
                    n_ok = r_found;
                end else if (r_op == OP_DELETE) begin
                    if (r_count != '0 && r_found) begin
                        meta_we = 1'b1;
                        meta_wa = r_idx;
                        meta_wd = '{mark: MARK_DELETED, lv: r_fmeta.lv, link: r_fmeta.link};
                        n_count = r_count - CW'(1);
                        n_ok    = 1'b1;
                    end
                end else if (r_op == OP_INSERT) begin
                    if (r_count == FULL || r_found) begin
                        n_ok = 1'b0;
                    end else if (r_hmeta.mark != MARK_FILLED) begin
                        meta_we = 1'b1;
                        meta_wa = r_home;
                        meta_wd = '{mark: MARK_FILLED, lv: r_hmeta.lv, link: r_hmeta.link};
                        kv_we   = 1'b1;
                        kv_wa   = r_home;
                        n_count = r_count + CW'(1);
                        n_ok    = 1'b1;
                    end else begin
                        n_cur   = '0;
                        n_state = S_SRD;
                    end
                end else begin
                    n_ok = 1'b0;
                end
            end
            S_SRD: begin
                n_state = S_SEV;
            end
            S_SEV: begin
                if (rd_meta.mark != MARK_FILLED) begin
                    meta_we = 1'b1;
                    meta_wd = '{mark: MARK_FILLED, lv: rd_meta.lv, link: rd_meta.link};
                    kv_we   = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                    n_slot  = r_cur;
                    n_cur   = r_home;
                    n_steps = '0;
                    n_state = S_WRD;
                end else if (r_cur == LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cur   = r_cur + IW'(1);
                    n_state = S_SRD;
                end
            end
            S_WRD: begin
                // Stop once the walk reaches the new slot: no self-link
                if (r_cur == r_slot) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_WEV;
                end
            end
            S_WEV: begin
                if (!rd_meta.lv) begin
                    meta_we = 1'b1;
                    meta_wd = '{mark: rd_meta.mark, lv: 1'b1, link: r_slot};
                    n_state = S_OUT;
                end else if (r_steps == LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cur   = rd_meta.link;
                    n_steps = r_steps + IW'(1);
                    n_state = S_WRD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cur   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_count <= n_count;
        end
    end

    // Working registers of the current transaction
    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_home  <= n_home;
        r_slot  <= n_slot;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_ok    <= n_ok;
        r_hmeta <= n_hmeta;
        r_fmeta <= n_fmeta;
        if (accept) begin
            r_op  <= i_in_data.op;
            r_key <= i_in_data.item_key;
            r_val <= i_in_data.item_value;
        end
    end

    assign count_ext = {5'd0, r_count};

    // Output register: load when free or being taken, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out <= '{success: r_ok, filled_slots: count_ext[4:0]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("fill count above table size");
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> o_in_stall)
        else $error("input accepted during clearing pass");
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_HASH))
        else $error("accepted transaction did not start hashing");
`endif

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for coalesced_hash_table: drives insert, lookup and delete
// transactions and checks each result against a predictor of the chained table.
// Depends on cht_pkg and the coalesced_hash_table RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cht_pkg::*;

    localparam int SLOTS       = 16;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 200;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    coalesced_hash_table #(.TABLE_SLOTS(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the table as the block should hold it
    logic [31:0] tbl_key [SLOTS];
    logic [31:0] tbl_data[SLOTS];
    logic [1:0]  tbl_mark[SLOTS];
    int          tbl_link[SLOTS];
    bit          tbl_has_link[SLOTS];
    int          tbl_count;

    t_out expected_results[$];
    int   mismatch_count = 0;
    int   result_count = 0;
    int   sent_count = 0;
    int   idle_cycles = 0;
    int   success_count = 0;
    bit   long_hold = 1'b0;
    bit   stall_pattern_on = 1'b1;

    function automatic int home_of(logic [31:0] key);
        logic [31:0] mag;
        mag = key[31] ? (32'd0 - key) : key;
        return int'(mag % SLOTS);
    endfunction

    function automatic int locate_key(logic [31:0] key);
        int cur;
        cur = home_of(key);
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_mark[cur] == MARK_FILLED && tbl_key[cur] == key) return cur;
            if (!tbl_has_link[cur]) break;
            cur = tbl_link[cur] % SLOTS;
        end
        return SLOTS;
    endfunction

    function automatic bit apply_insert(logic [31:0] key, logic [31:0] val);
        int home, slot, cur;
        if (tbl_count >= SLOTS || locate_key(key) < SLOTS) return 1'b0;
        home = home_of(key);
        if (tbl_mark[home] != MARK_FILLED) begin
            tbl_key[home] = key;
            tbl_data[home] = val;
            tbl_mark[home] = MARK_FILLED;
            tbl_count++;
            return 1'b1;
        end
        slot = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (tbl_mark[i] != MARK_FILLED) slot = i;
        if (slot >= SLOTS) return 1'b0;
        tbl_key[slot] = key;
        tbl_data[slot] = val;
        tbl_mark[slot] = MARK_FILLED;
        tbl_count++;
        // append to the home chain tail unless the slot already sits on it
        cur = home;
        for (int s = 0; s < SLOTS; s++) begin
            if (cur == slot) break;
            if (!tbl_has_link[cur]) begin
                tbl_link[cur] = slot;
                tbl_has_link[cur] = 1'b1;
                break;
            end
            cur = tbl_link[cur] % SLOTS;
        end
        return 1'b1;
    endfunction

    function automatic t_out predict_table_op(t_in item);
        t_out r;
        int idx;
        bit ok;
        ok = 1'b0;
        case (item.op)
            OP_INSERT: ok = apply_insert(item.item_key, item.item_value);
            OP_LOOKUP: ok = locate_key(item.item_key) < SLOTS;
            OP_DELETE: begin
                idx = locate_key(item.item_key);
                if (tbl_count != 0 && idx < SLOTS) begin
                    tbl_mark[idx] = MARK_DELETED;
                    tbl_count--;
                    ok = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
        r.success = ok;
        r.filled_slots = 5'(tbl_count);
        return r;
    endfunction

    // Send one transaction; hold it until accepted
    task automatic send_item(logic [1:0] op, logic [31:0] key, logic [31:0] val);
        t_in item;
        item.op = op;
        item.item_key = key;
        item.item_value = val;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_table_op(item));
        sent_count++;
    endtask

    // Sender gap between bursts, zero most of the time
    task automatic sender_gap();
        if ($urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [31:0] key_from_pool();
        // small pool of keys sharing home slots, so chains coalesce
        int base;
        base = $urandom_range(0, 23);
        case ($urandom_range(0, 3))
            0: return 32'(base);
            1: return 32'(-base);
            2: return 32'(base * SLOTS + $urandom_range(0, 2));
            default: return 32'(base) ^ 32'h8000_0000;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_DELETE, 32'd5, 32'd0);          // delete on an empty table
        send_item(OP_LOOKUP, 32'd5, 32'd0);
        send_item(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);   // most negative key
        send_item(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);   // -1 shares home of 1
        send_item(OP_INSERT, 32'd1, 32'd0);
        send_item(OP_INSERT, 32'd1, 32'd9);                   // key present
        send_item(OP_LOOKUP, 32'd1, 32'd0);
        send_item(OP_LOOKUP, 32'h8000_0000, 32'd0);
        send_item(OP_DELETE, 32'hffff_ffff, 32'd0);
        send_item(OP_LOOKUP, 32'd1, 32'd0);                   // walk past deleted slot
        send_item(OP_INSERT, 32'd17, 32'd3);                  // reuse deleted slot
        send_item(OP_UNKNOWN, 32'd1, 32'd0);                  // unknown op
        // fill the table, then one refused insert on a full table
        for (int k = 0; k < 12; k++) send_item(OP_INSERT, 32'(k * 16 + 2), 32'(k));
        send_item(OP_INSERT, 32'd99, 32'd1);
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        logic [1:0] op;
        logic [31:0] key;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 19) == 0) ? OP_UNKNOWN : 2'($urandom_range(0, 2));
            key = ($urandom_range(0, 9) == 0) ? $urandom() : key_from_pool();
            send_item(op, key, $urandom());
            sender_gap();
        end
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        long_hold = 1'b1;
        fork
            test_random_traffic(40);
            begin
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
        join
        wait_drained();
    endtask

    // Delete keys -20 through 20 from the table, then refill it with random traffic
    task automatic test_churn();
        for (int r = 0; r < 6; r++) begin
            for (int k = -20; k <= 20; k++) send_item(OP_DELETE, 32'(k), 32'd0);
            test_random_traffic(80);
        end
    endtask

    // Receiver stall pattern: busy bursts alternating with free stretches
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase % 300 == 0) stall_pattern_on = ~stall_pattern_on;
            i_out_stall <= long_hold ||
                (stall_pattern_on && ($urandom_range(0, 3) == 0));
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (o_out_data.success) success_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result %p", o_out_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_data.success !== exp_r.success ||
                    o_out_data.filled_slots !== exp_r.filled_slots) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch #%0d: expected success=%0b filled=%0d, got %0b %0d",
                                 result_count, exp_r.success, exp_r.filled_slots,
                                 o_out_data.success, o_out_data.filled_slots);
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_data[i] = '0;
            tbl_mark[i] = MARK_EMPTY;
            tbl_link[i] = 0;
            tbl_has_link[i] = 1'b0;
        end
        tbl_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(360);
        test_backpressure();
        wait_drained();           // sender pauses until the table has answered all
        test_churn();
        test_random_traffic(300);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d transactions, checked %0d results (%0d successful).",
                 sent_count, result_count, success_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, expected_results.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
